// File: sv/lfpe_pkg.sv
`default_nettype none
package lfpe_pkg;

    // Frame header bytes: sync before the two length bytes, then version, type and command.
    localparam logic [7:0] HDR_SYNC = 8'hAA;
    localparam logic [7:0] HDR_VER  = 8'h01;
    localparam logic [7:0] HDR_TYPE = 8'h61;
    localparam logic [7:0] HDR_CMD  = 8'hAD;

    // Angular span of one frame in hundredths of a degree (67.5 degrees).
    localparam logic [12:0] STEP_SPAN = 13'd6750;
    localparam logic [16:0] FULL_TURN_KEY = 17'd36000;
    localparam logic [9:0]  DEG_PER_TURN = 10'd360;
    localparam logic [6:0]  KEYS_PER_DEG = 7'd100;

    // Reciprocals for constant division: x/100 = (x*RECIP_100)>>23, x/3 = (x*RECIP_3)>>17.
    localparam logic [16:0] RECIP_100 = 17'd83887;
    localparam logic [16:0] RECIP_3   = 17'd43691;

    // Register reset values.
    localparam logic [7:0]  QUALITY_FLOOR_RST = 8'd100;
    localparam logic [15:0] KEEP_LIMIT_RST    = 16'd8000;
    localparam logic [8:0]  ANGLE_OFFSET_RST  = 9'd270;

    typedef enum logic [1:0] {
        CFG_QUALITY_FLOOR = 2'd0,
        CFG_KEEP_LIMIT    = 2'd1,
        CFG_ANGLE_OFFSET  = 2'd2
    } cfg_index_t;

    typedef enum logic [1:0] {
        BK_CLEAR  = 2'd0,
        BK_IDLE   = 2'd1,
        BK_LOOKUP = 2'd2
    } back_state_t;

    // One command from the parser to the table side.
    typedef struct packed {
        logic        is_read;
        logic [15:0] key;
        logic [15:0] raw_range;
        logic [7:0]  quality;
    } cmd_t;

    // Status from the table side to the parser.
    typedef struct packed {
        logic clearing;
    } back_status_t;

endpackage
`default_nettype wire

// File: sv/lidar_frame_point_extractor.sv
// A read goes to the queue when taken, a reported sample from the pending register
// after its last byte; the idle table side pops it, reads the table and raises m_tvalid
// with the registered result once the output is free. Throughput: one byte a cycle while
// s_tready is high; input stalls after a reported sample's last byte and while the
// 13-step angle divider runs after the data length byte; the table side takes one command
// at a time. Reset (aresetn low, synchronous) restores the registers, then clears all
// ANGLE_KEYS table entries, one entry a cycle, taking no input, then hunts for a header.
`default_nettype none
module lidar_frame_point_extractor
    import lfpe_pkg::*;
#(
    parameter int ANGLE_KEYS = 36001
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // rx_byte [7:0], read_key [23:8]
    input  wire logic        s_tuser,   // operation
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,   // angle_key [15:0], distance_q [31:16], quality [39:32]
    output logic             m_tuser,   // stored
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_wdata
);

    logic [7:0]   quality_floor_reg;
    logic [15:0]  keep_limit_reg;
    logic [8:0]   angle_offset_reg;
    back_status_t status;
    logic         q_full;
    logic         q_empty;
    logic         q_push;
    logic         q_pop;
    cmd_t         q_in;
    cmd_t         q_out;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            quality_floor_reg <= QUALITY_FLOOR_RST;
            keep_limit_reg    <= KEEP_LIMIT_RST;
            angle_offset_reg  <= ANGLE_OFFSET_RST;
        end else if (cfg_we) begin
            unique case (cfg_index_t'(cfg_index))
                CFG_QUALITY_FLOOR: quality_floor_reg <= cfg_wdata[7:0];
                CFG_KEEP_LIMIT:    keep_limit_reg    <= cfg_wdata;
                CFG_ANGLE_OFFSET:  angle_offset_reg  <= cfg_wdata[8:0];
                default:           quality_floor_reg <= quality_floor_reg;
            endcase
        end
    end

    lfpe_front u_front (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_tvalid         (s_tvalid),
        .s_tready         (s_tready),
        .s_tdata          (s_tdata),
        .s_tuser          (s_tuser),
        .quality_floor    (quality_floor_reg),
        .angle_offset_deg (angle_offset_reg),
        .status           (status),
        .q_full           (q_full),
        .q_push           (q_push),
        .q_data           (q_in)
    );

    lfpe_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_out),
        .empty     (q_empty)
    );

    lfpe_back #(
        .ANGLE_KEYS (ANGLE_KEYS)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_empty    (q_empty),
        .q_pop      (q_pop),
        .q_data     (q_out),
        .keep_limit (keep_limit_reg),
        .status     (status),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

endmodule
`default_nettype wire

// File: sv/lfpe_ram.sv
`default_nettype none
module lfpe_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 36001
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]              rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port and one registered read port.
    always_ff @(posedge clk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

// File: sv/lfpe_div.sv
`default_nettype none
module lfpe_div
    import lfpe_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        start,
    input  wire logic [15:0] divisor,
    output logic             busy,
    output logic [12:0]      quotient,
    output logic [15:0]      remainder
);

    logic [15:0] dvs_reg;
    logic [12:0] quo_reg;
    logic [15:0] rem_reg;
    logic [3:0]  cnt_reg;
    logic        busy_reg;

    logic [16:0] shifted;
    logic        fits;

    // One restoring step: bring down the next dividend bit and try a subtract.
    assign shifted = {rem_reg, quo_reg[12]};
    assign fits    = shifted >= {1'b0, dvs_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= 4'd0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= 4'd13;
        end else if (busy_reg) begin
            cnt_reg  <= cnt_reg - 4'd1;
            busy_reg <= cnt_reg != 4'd1;
        end
    end

    // The dividend is shifted out of the quotient register as quotient bits come in.
    always_ff @(posedge aclk) begin
        if (start) begin
            dvs_reg <= divisor;
            quo_reg <= STEP_SPAN;
            rem_reg <= 16'd0;
        end else if (busy_reg) begin
            quo_reg <= {quo_reg[11:0], fits};
            rem_reg <= fits ? 16'(shifted - {1'b0, dvs_reg}) : shifted[15:0];
        end
    end

    assign busy      = busy_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule
`default_nettype wire

// File: sv/lfpe_queue.sv
`default_nettype none
module lfpe_queue
    import lfpe_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic push,
    input  wire cmd_t push_data,
    output logic      full,
    input  wire logic pop,
    output cmd_t      pop_data,
    output logic      empty
);

    cmd_t       ent_reg [2];
    logic       wp_reg;
    logic       rp_reg;
    logic [1:0] cnt_reg;

    assign full     = cnt_reg == 2'd2;
    assign empty    = cnt_reg == 2'd0;
    assign pop_data = ent_reg[rp_reg];

    // Two-entry circular queue of commands.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (push) begin
                wp_reg <= ~wp_reg;
            end
            if (pop) begin
                rp_reg <= ~rp_reg;
            end
            if (push && !pop) begin
                cnt_reg <= cnt_reg + 2'd1;
            end else if (pop && !push) begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            ent_reg[wp_reg] <= push_data;
        end
    end

endmodule
`default_nettype wire

// File: sv/lfpe_front.sv
`default_nettype none
module lfpe_front
    import lfpe_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [23:0]  s_tdata,   // rx_byte [7:0], read_key [23:8]
    input  wire logic         s_tuser,   // operation
    input  wire logic [7:0]   quality_floor,
    input  wire logic [8:0]   angle_offset_deg,
    input  wire back_status_t status,
    input  wire logic         q_full,
    output logic              q_push,
    output cmd_t              q_data
);

    logic [39:0] hw_reg, hw_next;
    logic [16:0] off_reg, off_next;
    logic [16:0] flen_reg, flen_next;
    logic [15:0] sbytes_reg, sbytes_next;
    logic [15:0] divisor_reg, divisor_next;
    logic [14:0] n_reg, n_next;
    logic [1:0]  phase_reg, phase_next;
    logic        setup_reg, setup_next;
    logic        pend_reg, pend_next;
    logic [7:0]  pq_reg, pq_next;
    logic [15:0] pd_reg, pd_next;
    logic [15:0] qacc_reg, qacc_next;
    logic [15:0] racc_reg, racc_next;
    logic [15:0] raw_reg, raw_next;
    logic [9:0]  qdeg_reg;
    logic [15:0] skey_reg;

    logic        accept;
    logic        byte_acc;
    logic [7:0]  b;
    logic [15:0] pair;
    logic        hdr_match;
    logic        is_sample;
    logic [16:0] o_plus1;
    logic [15:0] dlm6;
    logic [32:0] n_prod;
    logic [15:0] sb_new;
    logic [16:0] span;
    logic [16:0] rs;
    logic        adj;
    logic        div_start;
    logic        div_busy;
    logic [12:0] quo;
    logic [15:0] rem;
    logic [32:0] deg_prod;
    logic [9:0]  deg_m;
    logic [9:0]  deg_s;
    logic [9:0]  deg_w;
    logic [16:0] key_sum;
    logic [15:0] key_w;

    assign s_tready = !status.clearing && !div_busy && !setup_reg && !pend_reg && !q_full;
    assign accept   = s_tvalid && s_tready;
    assign byte_acc = accept && !s_tuser;
    assign b        = s_tdata[7:0];
    assign pair     = {hw_reg[7:0], b};

    assign hdr_match = hw_reg[39:32] == HDR_SYNC && hw_reg[15:8] == HDR_VER &&
                       hw_reg[7:0] == HDR_TYPE && b == HDR_CMD;
    assign o_plus1   = off_reg + 17'd1;
    assign is_sample = off_reg >= 17'd13 && off_reg < 17'd13 + {1'b0, sbytes_reg} &&
                       phase_reg == 2'd2;

    // Sample count from the data length: (dl - 6) / 3 by reciprocal.
    assign dlm6   = pair - 16'd6;
    assign n_prod = {17'd0, dlm6} * {16'd0, RECIP_3};
    assign sb_new = 16'({1'b0, n_reg} + {n_reg, 1'b0});
    assign span   = 17'd13 + {1'b0, sb_new};

    // Per-sample angle step: quotient and remainder accumulate, one carry per step.
    assign rs  = {1'b0, racc_reg} + {1'b0, rem};
    assign adj = rs >= {1'b0, divisor_reg};

    // Start angle: degrees of the raw angle, plus offset, wrapped, times 100.
    assign deg_prod = {17'd0, raw_reg} * {16'd0, RECIP_100};
    assign deg_m    = qdeg_reg >= DEG_PER_TURN ? qdeg_reg - DEG_PER_TURN : qdeg_reg;
    assign deg_s    = deg_m + {1'b0, angle_offset_deg};

    always_comb begin
        priority if (deg_s >= {DEG_PER_TURN[8:0], 1'b0}) begin
            deg_w = deg_s - {DEG_PER_TURN[8:0], 1'b0};
        end else if (deg_s >= DEG_PER_TURN) begin
            deg_w = deg_s - DEG_PER_TURN;
        end else begin
            deg_w = deg_s;
        end
    end

    // Angle key of a pending sample, wrapped into one turn.
    assign key_sum = {1'b0, skey_reg} + {1'b0, qacc_reg};
    assign key_w   = key_sum > FULL_TURN_KEY ? 16'(key_sum - FULL_TURN_KEY) : key_sum[15:0];

    // Byte parser: header hunt, then walk one frame.
    always_comb begin
        hw_next      = hw_reg;
        off_next     = off_reg;
        flen_next    = flen_reg;
        sbytes_next  = sbytes_reg;
        divisor_next = divisor_reg;
        n_next       = n_reg;
        phase_next   = phase_reg;
        setup_next   = 1'b0;
        pend_next    = 1'b0;
        pq_next      = pq_reg;
        pd_next      = pd_reg;
        qacc_next    = qacc_reg;
        racc_next    = racc_reg;
        raw_next     = raw_reg;
        div_start    = 1'b0;

        if (setup_reg) begin
            sbytes_next = sb_new;
            flen_next   = span > flen_reg ? span : flen_reg;
        end

        if (byte_acc) begin
            hw_next = {hw_reg[31:0], b};
            if (off_reg == 17'd0) begin
                if (hdr_match) begin
                    flen_next = {1'b0, hw_reg[31:16]};
                    off_next  = 17'd6;
                end
            end else begin
                if (off_reg == 17'd7) begin
                    divisor_next = pair - 16'd5;
                    n_next       = pair >= 16'd9 ? n_prod[31:17] : 15'd0;
                    div_start    = 1'b1;
                    setup_next   = 1'b1;
                    qacc_next    = 16'd0;
                    racc_next    = 16'd0;
                end
                if (off_reg == 17'd12) begin
                    raw_next   = pair;
                    phase_next = 2'd0;
                end else if (off_reg >= 17'd13) begin
                    phase_next = phase_reg == 2'd2 ? 2'd0 : phase_reg + 2'd1;
                end
                if (is_sample) begin
                    racc_next = adj ? 16'(rs - {1'b0, divisor_reg}) : rs[15:0];
                    qacc_next = qacc_reg + {3'd0, quo} + {15'd0, adj};
                    if (hw_reg[15:8] > quality_floor && pair != 16'd0) begin
                        pend_next = 1'b1;
                        pq_next   = hw_reg[15:8];
                        pd_next   = pair;
                    end
                end
                if (off_reg >= 17'd8 && o_plus1 >= flen_reg) begin
                    off_next = 17'd0;
                    hw_next  = 40'd0;
                end else begin
                    off_next = o_plus1;
                end
            end
        end
    end

    // Reads go straight to the queue; samples follow in the cycle after their last byte, with their key.
    always_comb begin
        q_push = 1'b0;
        q_data = '0;
        if (pend_reg) begin
            q_push            = 1'b1;
            q_data.is_read    = 1'b0;
            q_data.key        = key_w;
            q_data.raw_range  = pd_reg;
            q_data.quality    = pq_reg;
        end else if (accept && s_tuser) begin
            q_push          = 1'b1;
            q_data.is_read  = 1'b1;
            q_data.key      = s_tdata[23:8];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hw_reg     <= 40'd0;
            off_reg    <= 17'd0;
            flen_reg   <= 17'd0;
            sbytes_reg <= 16'd0;
            phase_reg  <= 2'd0;
            setup_reg  <= 1'b0;
            pend_reg   <= 1'b0;
        end else begin
            hw_reg     <= hw_next;
            off_reg    <= off_next;
            flen_reg   <= flen_next;
            sbytes_reg <= sbytes_next;
            phase_reg  <= phase_next;
            setup_reg  <= setup_next;
            pend_reg   <= pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        divisor_reg <= divisor_next;
        n_reg       <= n_next;
        pq_reg      <= pq_next;
        pd_reg      <= pd_next;
        qacc_reg    <= qacc_next;
        racc_reg    <= racc_next;
        raw_reg     <= raw_next;
        qdeg_reg    <= deg_prod[32:23];
        skey_reg    <= 16'({6'd0, deg_w} * {9'd0, KEYS_PER_DEG});
    end

    lfpe_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .divisor   (divisor_next),
        .busy      (div_busy),
        .quotient  (quo),
        .remainder (rem)
    );

endmodule
`default_nettype wire

// File: sv/lfpe_back.sv
`default_nettype none
module lfpe_back
    import lfpe_pkg::*;
#(
    parameter int ANGLE_KEYS = 36001
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        q_empty,
    output logic             q_pop,
    input  wire cmd_t        q_data,
    input  wire logic [15:0] keep_limit,
    output back_status_t     status,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,
    output logic             m_tuser
);

    localparam int AW = $clog2(ANGLE_KEYS);
    localparam logic [AW-1:0] LAST_KEY  = AW'(ANGLE_KEYS - 1);
    localparam logic [16:0]   KEY_LIMIT = 17'(ANGLE_KEYS);

    back_state_t   state_reg, state_next;
    logic [AW-1:0] clr_reg;
    cmd_t          cmd_reg;
    logic          inr_reg;
    logic          mval_reg;
    logic [39:0]   mdata_reg;
    logic          muser_reg;

    logic          out_free;
    logic          emit;
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [15:0]   ram_wdata;
    logic          ram_re;
    logic [15:0]   ram_rdata;
    logic [15:0]   tbl;
    logic [16:0]   sum;
    logic [15:0]   avg;
    logic          keep;

    assign out_free = !mval_reg || m_tready;

    // Averaging with the stored entry; keys beyond the table read as zero.
    assign tbl  = inr_reg ? ram_rdata : 16'd0;
    assign sum  = {1'b0, cmd_reg.raw_range} + {1'b0, tbl};
    assign avg  = sum[16:1];
    assign keep = !cmd_reg.is_read && inr_reg && avg < keep_limit;

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            BK_CLEAR: begin
                if (clr_reg == LAST_KEY) begin
                    state_next = BK_IDLE;
                end
            end
            BK_IDLE: begin
                if (!q_empty) begin
                    state_next = BK_LOOKUP;
                end
            end
            BK_LOOKUP: begin
                if (out_free) begin
                    state_next = BK_IDLE;
                end
            end
            default: state_next = BK_CLEAR;
        endcase
    end

    // Outputs per state.
    always_comb begin
        q_pop     = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = clr_reg;
        ram_wdata = 16'd0;
        ram_re    = 1'b0;
        emit      = 1'b0;
        unique case (state_reg)
            BK_CLEAR: begin
                ram_we = 1'b1;
            end
            BK_IDLE: begin
                q_pop  = !q_empty;
                ram_re = !q_empty;
            end
            BK_LOOKUP: begin
                emit      = out_free;
                ram_we    = out_free && keep;
                ram_waddr = cmd_reg.key[AW-1:0];
                ram_wdata = avg;
            end
            default: begin
                q_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= BK_CLEAR;
            clr_reg   <= '0;
            mval_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == BK_CLEAR) begin
                clr_reg <= clr_reg + AW'(1);
            end
            if (emit) begin
                mval_reg <= 1'b1;
            end else if (m_tready) begin
                mval_reg <= 1'b0;
            end
        end
    end

    // Command and result payload.
    always_ff @(posedge aclk) begin
        if (q_pop) begin
            cmd_reg <= q_data;
            inr_reg <= {1'b0, q_data.key} < KEY_LIMIT;
        end
        if (emit) begin
            mdata_reg <= {cmd_reg.is_read ? 8'd0 : cmd_reg.quality,
                          cmd_reg.is_read ? tbl : avg, cmd_reg.key};
            muser_reg <= keep;
        end
    end

    lfpe_ram #(
        .WIDTH (16),
        .DEPTH (ANGLE_KEYS)
    ) u_table (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (q_data.key[AW-1:0]),
        .rdata (ram_rdata)
    );

    assign status.clearing = state_reg == BK_CLEAR;
    assign m_tvalid = mval_reg;
    assign m_tdata  = mdata_reg;
    assign m_tuser  = muser_reg;

    // A table update never goes to a key outside the table.
    a_write_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (ram_we && state_reg == BK_LOOKUP) |-> inr_reg)
        else $error("table write at a key beyond the table");

    // No result leaves while the table is being cleared.
    a_quiet_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == BK_CLEAR) |-> !mval_reg)
        else $error("result shown during table clear");

    // A stored result always lies below the keep limit.
    a_stored_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        (mval_reg && muser_reg) |-> (mdata_reg[31:16] < keep_limit))
        else $error("stored distance not below keep limit");

endmodule
`default_nettype wire

// File: tb/lidar_frame_point_extractor_check.sv
`timescale 1ns / 1ps
module lidar_frame_point_extractor_check
    import lfpe_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [23:0] s_tdata,
    input  wire logic        s_tuser,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [39:0] m_tdata,
    input  wire logic        m_tuser,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_wdata,
    output int               fail_count,
    output int               points_pending
);

    localparam int KEYS = 36001;

    typedef struct packed {
        logic [15:0] angle_key;
        logic [15:0] distance_q;
        logic [7:0]  quality;
        logic        stored;
    } point_t;

    // Predictor state.
    logic [7:0]  quality_floor;
    logic [15:0] keep_limit;
    logic [8:0]  angle_offset_deg;
    logic [39:0] hdr_window;
    int unsigned frame_pos;
    int unsigned frame_len;
    logic [15:0] payload_len;
    logic [15:0] frame_start_key;
    logic [15:0] span_bytes;
    logic [15:0] range_table [KEYS];
    point_t      point_queue [$];

    assign points_pending = point_queue.size();

    function automatic logic [15:0] table_value(int unsigned key);
        return key < KEYS ? range_table[key] : 16'd0;
    endfunction

    // Advance the frame parser by one byte transfer, queueing any point it yields.
    task automatic parse_byte(logic [7:0] b);
        logic [39:0] w;
        logic [7:0]  prev;
        logic [7:0]  prev2;
        int unsigned dl;
        int unsigned n;
        int unsigned raw;
        int unsigned k;
        int unsigned key;
        int unsigned avg;
        int unsigned div;
        int unsigned o;
        point_t      p;
        w = hdr_window;
        prev = w[7:0];
        prev2 = w[15:8];
        hdr_window = {w[31:0], b};
        if (frame_pos == 0) begin
            if (w[39:32] == HDR_SYNC && w[15:8] == HDR_VER && w[7:0] == HDR_TYPE
                    && b == HDR_CMD) begin
                frame_len = w[31:16];
                frame_pos = 6;
            end
            return;
        end
        o = frame_pos;
        if (o == 7) begin
            dl = {prev, b};
            n = dl >= 9 ? (dl - 6) / 3 : 0;
            payload_len = 16'(dl);
            span_bytes = 16'(3 * n);
            if (13 + 3 * n > frame_len) frame_len = 13 + 3 * n;
        end else if (o == 12) begin
            raw = {prev, b};
            frame_start_key = 16'((((raw / 100) % 360 + angle_offset_deg) % 360) * 100);
        end else if (o >= 13 && o < 13 + span_bytes && (o - 13) % 3 == 2) begin
            k = (o - 13) / 3 + 1;
            raw = {prev, b};
            div = payload_len - 5;
            if (prev2 > quality_floor && raw != 0 && div != 0) begin
                key = frame_start_key + (6750 * k) / div;
                while (key > 36000) key -= 36000;
                avg = (raw + table_value(key)) >> 1;
                p.angle_key = 16'(key);
                p.distance_q = 16'(avg);
                p.quality = prev2;
                p.stored = avg < keep_limit && key < KEYS;
                if (p.stored) range_table[key] = 16'(avg);
                point_queue = {point_queue, p};
            end
        end
        if (o >= 7 && o + 1 >= frame_len) begin
            frame_pos = 0;
            hdr_window = '0;
        end else begin
            frame_pos = o + 1;
        end
    endtask

    always @(posedge aclk) begin
        point_t got;
        point_t want;
        point_t rd;
        if (!aresetn) begin
            quality_floor = QUALITY_FLOOR_RST;
            keep_limit = KEEP_LIMIT_RST;
            angle_offset_deg = ANGLE_OFFSET_RST;
            hdr_window = '0;
            frame_pos = 0;
            frame_len = 0;
            payload_len = '0;
            frame_start_key = '0;
            span_bytes = '0;
            foreach (range_table[i]) range_table[i] = '0;
            point_queue.delete();
            fail_count = 0;
        end else begin
            // Register writes.
            if (cfg_we) begin
                case (cfg_index)
                    CFG_QUALITY_FLOOR: quality_floor = cfg_wdata[7:0];
                    CFG_KEEP_LIMIT:    keep_limit = cfg_wdata;
                    CFG_ANGLE_OFFSET:  angle_offset_deg = cfg_wdata[8:0];
                    default: ;
                endcase
            end
            // Check the result transfer against the oldest prediction.
            if (m_tvalid && m_tready) begin
                got = {m_tdata[15:0], m_tdata[31:16], m_tdata[39:32], m_tuser};
                if (point_queue.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result: key %0d dist %0d q %0d stored %0d",
                                 got.angle_key, got.distance_q, got.quality, got.stored);
                end else begin
                    want = point_queue.pop_front();
                    if (got !== want) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch: expected key %0d dist %0d q %0d st %0d, %s",
                                     want.angle_key, want.distance_q, want.quality,
                                     want.stored, $sformatf("got key %0d dist %0d q %0d st %0d",
                                     got.angle_key, got.distance_q, got.quality, got.stored));
                    end
                end
            end
            // Predict the result of an input transfer.
            if (s_tvalid && s_tready) begin
                if (s_tuser) begin
                    rd.angle_key = s_tdata[23:8];
                    rd.distance_q = table_value(s_tdata[23:8]);
                    rd.quality = '0;
                    rd.stored = 1'b0;
                    point_queue = {point_queue, rd};
                end else begin
                    parse_byte(s_tdata[7:0]);
                end
            end
        end
    end

endmodule

// File: tb/lidar_frame_point_extractor_test.sv
`timescale 1ns / 1ps
module lidar_frame_point_extractor_test;
    import lfpe_pkg::*;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;
    logic        m_tuser;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_wdata;
    int          fail_count;
    int          points_pending;
    int          hold_cycles;
    int          hold_req;
    int          hold_seen;
    bit          sink_random;

    lidar_frame_point_extractor i_dut (.*);

    lidar_frame_point_extractor_check i_check (.*);

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Receiver: random stalls, plus a long hold-off on request.
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            hold_cycles <= 0;
            hold_seen <= 0;
        end else if (hold_seen != hold_req) begin
            hold_seen <= hold_req;
            hold_cycles <= 400;
            m_tready <= 1'b0;
        end else if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_tready <= 1'b0;
        end else if (!sink_random) begin
            m_tready <= 1'b1;
        end else begin
            m_tready <= gap_len() == 0;
        end
    end

    // Offer one item and wait for its transfer.
    task automatic send_item(logic op, logic [7:0] b, logic [15:0] key, bit paced);
        int g;
        g = paced ? gap_len() : 0;
        if (g > 0) begin
            s_tvalid <= 1'b0;
            repeat (g) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {key, b};
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    task automatic send_byte(logic [7:0] b, bit paced);
        send_item(1'b0, b, 16'($urandom), paced);
    endtask

    task automatic send_read(logic [15:0] key, bit paced);
        send_item(1'b1, 8'($urandom), key, paced);
    endtask

    // A whole frame with random samples; quality mostly above the floor.
    task automatic send_frame(int n, int pkt_len, logic [15:0] start_raw, bit paced);
        int dl;
        logic [7:0] q;
        logic [15:0] d;
        dl = 3 * n + 6 + $urandom_range(0, 2);
        if (n == 0) dl = $urandom_range(0, 8);
        send_byte(HDR_SYNC, paced);
        send_byte(pkt_len[15:8], paced);
        send_byte(pkt_len[7:0], paced);
        send_byte(HDR_VER, paced);
        send_byte(HDR_TYPE, paced);
        send_byte(HDR_CMD, paced);
        send_byte(dl[15:8], paced);
        send_byte(dl[7:0], paced);
        repeat (3) send_byte(8'($urandom), paced);
        send_byte(start_raw[15:8], paced);
        send_byte(start_raw[7:0], paced);
        for (int i = 0; i < n; i++) begin
            q = $urandom_range(0, 9) == 0 ? 8'($urandom) : 8'($urandom_range(101, 255));
            d = $urandom_range(0, 19) == 0 ? 16'd0 :
                ($urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(1, 16000)));
            send_byte(q, paced);
            send_byte(d[15:8], paced);
            send_byte(d[7:0], paced);
        end
        for (int i = 13 + 3 * n; i < pkt_len; i++) send_byte(8'($urandom), paced);
    endtask

    // Let the block drain, then write a register.
    task automatic write_reg(cfg_index_t idx, logic [15:0] val);
        s_tvalid <= 1'b0;
        while (points_pending != 0) @(negedge aclk);
        repeat (20) @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    initial begin
        #40_000_000;
        $display("lidar_frame_point_extractor_test: FAIL");
        $finish;
    end

    initial begin
        int items;
        int wait_count;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_QUALITY_FLOOR;
        cfg_wdata = '0;
        hold_req = 0;
        sink_random = 1'b0;
        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: reads at the key extremes, frames at reset settings.
        send_read(16'd0, 0);
        send_read(16'd36000, 0);
        send_read(16'hFFFF, 0);
        send_frame(2, 0, 16'd0, 0);            // short packet length raised
        send_frame(0, 13, 16'hFFFF, 0);        // small data length, no samples
        send_read(16'd27000, 0);
        // Read in the middle of a frame.
        send_byte(HDR_SYNC, 0);
        send_byte(8'd0, 0);
        send_byte(8'd15, 0);
        send_byte(HDR_VER, 0);
        send_byte(HDR_TYPE, 0);
        send_byte(HDR_CMD, 0);
        send_read(16'd1, 0);
        send_byte(8'd0, 0);
        send_byte(8'd9, 0);
        repeat (5) send_byte(8'hFF, 0);
        send_byte(8'hFF, 0);
        send_byte(8'hFF, 0);
        send_byte(8'hFF, 0);

        // Register extremes, with long stall pressure on the first frame.
        write_reg(CFG_QUALITY_FLOOR, 16'd0);
        write_reg(CFG_KEEP_LIMIT, 16'hFFFF);
        write_reg(CFG_ANGLE_OFFSET, 16'd359);
        hold_req = 1;
        send_frame(12, 60, 16'd35999, 0);
        send_frame(4, 0, 16'd9000, 0);
        write_reg(CFG_QUALITY_FLOOR, 16'd255);
        write_reg(CFG_KEEP_LIMIT, 16'd0);
        write_reg(CFG_ANGLE_OFFSET, 16'd0);
        send_frame(3, 0, 16'd100, 0);

        // Random phases with different settings.
        sink_random = 1'b1;
        items = 0;
        for (int phase = 0; phase < 4; phase++) begin
            write_reg(CFG_QUALITY_FLOOR, phase == 0 ? 16'd100 : 16'($urandom_range(0, 200)));
            write_reg(CFG_KEEP_LIMIT,
                      phase == 1 ? 16'hFFFF : 16'($urandom_range(2000, 12000)));
            write_reg(CFG_ANGLE_OFFSET, 16'($urandom_range(0, 359)));
            for (int f = 0; f < 6; f++) begin
                send_frame($urandom_range(1, 12), $urandom_range(0, 1) ? 0 :
                           $urandom_range(13, 60), 16'($urandom), 1);
                repeat ($urandom_range(0, 4)) begin
                    if ($urandom_range(0, 1)) send_read(16'($urandom_range(0, 36000)), 1);
                    else if ($urandom_range(0, 3) == 0) send_read(16'($urandom), 1);
                    else send_byte($urandom_range(0, 1) ? HDR_SYNC : 8'($urandom), 1);
                end
            end
        end

        s_tvalid <= 1'b0;
        wait_count = 0;
        while (points_pending != 0 && wait_count < 100000) begin
            @(negedge aclk);
            wait_count++;
        end
        repeat (20) @(negedge aclk);
        if (fail_count == 0 && points_pending == 0) begin
            $display("lidar_frame_point_extractor_test: PASS");
        end else begin
            $display("lidar_frame_point_extractor_test: FAIL");
        end
        $finish;
    end

endmodule
